@@ rtl/mmed_pkg.sv @@
// Shared types and constants for the min/max envelope decimator.
`default_nettype none

package mmed_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COL_W    = 5;
    localparam int AXES_W   = 6;
    localparam int ROW_W    = 16;
    localparam int OUTCOL_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPB      = 4'd1;

    typedef struct packed {
        logic [AXES_W-1:0] num_axes;
        logic [ROW_W-1:0]  samples_per_bucket;
    } t_cfg;

    // One classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]           col;
        logic                       first_row;
        logic                       last_row;
        logic                       last_col;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/mmed_front.sv @@
// Front end: accept samples, track column and row, classify kept columns.
`default_nettype none

module mmed_front #(
    parameter int MAX_COLUMNS = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire mmed_pkg::t_cfg                  i_cfg,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [mmed_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                  i_q_full,
    output logic                                 o_push,
    output mmed_pkg::t_entry                     o_entry
);

    localparam logic [mmed_pkg::AXES_W-1:0] KEPT_MAX = mmed_pkg::AXES_W'(MAX_COLUMNS);

    logic [mmed_pkg::COL_W-1:0]  r_col, n_col;
    logic [mmed_pkg::ROW_W-1:0]  r_row, n_row;
    logic [mmed_pkg::AXES_W-1:0] axes, kept, col_ext;
    logic [mmed_pkg::ROW_W-1:0]  spb;
    logic                        accept, last_row, col_kept, row_end;

    always_comb begin
        // clamp axis count to 1..32 and bucket length to at least one row
        if (i_cfg.num_axes == '0) begin
            axes = mmed_pkg::AXES_W'(1);
        end else if (i_cfg.num_axes > mmed_pkg::AXES_W'(32)) begin
            axes = mmed_pkg::AXES_W'(32);
        end else begin
            axes = i_cfg.num_axes;
        end
        kept     = (axes < KEPT_MAX) ? axes : KEPT_MAX;
        spb      = (i_cfg.samples_per_bucket == '0) ? mmed_pkg::ROW_W'(1)
                                                    : i_cfg.samples_per_bucket;
        col_ext  = {1'b0, r_col};
        last_row = (r_row >= (spb - mmed_pkg::ROW_W'(1)));
        col_kept = (col_ext < kept);
        row_end  = (col_ext >= (axes - mmed_pkg::AXES_W'(1)));

        o_in_ready = !i_q_full;
        accept     = i_in_valid && o_in_ready;
        o_push     = accept && col_kept;

        o_entry.sample    = i_sample;
        o_entry.col       = r_col;
        o_entry.first_row = (r_row == '0);
        o_entry.last_row  = last_row;
        o_entry.last_col  = (col_ext == (kept - mmed_pkg::AXES_W'(1)));

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + mmed_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + mmed_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmed_queue.sv @@
// Two-entry queue between the front and back ends.
`default_nettype none

module mmed_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire mmed_pkg::t_entry  i_entry,
    input  wire                    i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output mmed_pkg::t_entry       o_head
);

    localparam int DEPTH = 2;

    mmed_pkg::t_entry r_mem [DEPTH];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmed_back.sv @@
// Back end: per-column min/max update and registered result beat.
`default_nettype none

module mmed_back #(
    parameter int MAX_COLUMNS = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_head_valid,
    input  wire mmed_pkg::t_entry                 i_head,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [mmed_pkg::OUTCOL_W-1:0]         o_column,
    output logic signed [mmed_pkg::SAMPLE_W-1:0]  o_min_value,
    output logic signed [mmed_pkg::SAMPLE_W-1:0]  o_max_value,
    output logic                                  o_last
);

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic signed [mmed_pkg::SAMPLE_W-1:0] r_min [MAX_COLUMNS];
    logic signed [mmed_pkg::SAMPLE_W-1:0] r_max [MAX_COLUMNS];
    logic signed [mmed_pkg::SAMPLE_W-1:0] cur_min, cur_max, n_min, n_max;
    logic [IDX_W-1:0]                     idx;
    logic                                 emit;

    always_comb begin
        idx     = i_head.col[IDX_W-1:0];
        cur_min = r_min[idx];
        cur_max = r_max[idx];
        n_min   = cur_min;
        n_max   = cur_max;
        // first row loads both; otherwise at most one side moves
        if (i_head.first_row) begin
            n_min = i_head.sample;
            n_max = i_head.sample;
        end else if (i_head.sample < cur_min) begin
            n_min = i_head.sample;
        end else if (cur_max < i_head.sample) begin
            n_max = i_head.sample;
        end
        emit  = i_head.last_row;
        o_pop = i_head_valid && (!emit || !o_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_min[idx] <= n_min;
            r_max[idx] <= n_max;
        end
        if (o_pop && emit) begin
            o_column    <= i_head.col[mmed_pkg::OUTCOL_W-1:0];
            o_min_value <= n_min;
            o_max_value <= n_max;
            o_last      <= i_head.last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/minmax_envelope_decimator_top.sv @@
// An accepted sample beat enters the queue; its result beat is registered on pop.
// Throughput: one sample beat per cycle while the result channel does not stall,
// set by the compare-and-update of per-column min/max registers in the back end.
// The two-entry queue and the output register let the input keep flowing while
// a result beat waits. Reset is synchronous, active low: it clears the counters,
// the queue and the output valid; configuration returns to one axis, one row.
`default_nettype none

module minmax_envelope_decimator_top #(
    parameter int MAX_COLUMNS = 8
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // sample channel
    input  wire                                      i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [mmed_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output logic [mmed_pkg::OUTCOL_W-1:0]            o_column,
    output logic signed [mmed_pkg::SAMPLE_W-1:0]     o_min_value,
    output logic signed [mmed_pkg::SAMPLE_W-1:0]     o_max_value,
    output logic                                     o_last,
    // configuration write channel
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire [mmed_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire [mmed_pkg::CFG_DATA_W-1:0]           i_cfg_data
);

    mmed_pkg::t_cfg   r_cfg;
    mmed_pkg::t_entry push_entry, head;
    logic             push, pop, q_full, q_valid;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_axes           <= mmed_pkg::AXES_W'(1);
            r_cfg.samples_per_bucket <= mmed_pkg::ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mmed_pkg::REG_NUM_AXES: begin
                    r_cfg.num_axes <= i_cfg_data[mmed_pkg::AXES_W-1:0];
                end
                mmed_pkg::REG_SPB: begin
                    r_cfg.samples_per_bucket <= i_cfg_data[mmed_pkg::ROW_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front: count columns and rows, push only kept columns.
    mmed_front #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Queue: decouple the sample stall from the result stall.
    mmed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    // Back: update the envelope and present result beats.
    mmed_back #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_column     (o_column),
        .o_min_value  (o_min_value),
        .o_max_value  (o_max_value),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/mmed_checker.sv @@
// Port-level checker for the min/max envelope decimator, bound to the top level.
`default_nettype none

module mmed_checker (
    input wire                                       i_clk,
    input wire                                       i_rst_n,
    input wire                                       o_in_ready,
    input wire                                       o_out_valid,
    input wire                                       i_out_ready,
    input wire [mmed_pkg::OUTCOL_W-1:0]              o_column,
    input wire [mmed_pkg::SAMPLE_W-1:0]              o_min_value,
    input wire [mmed_pkg::SAMPLE_W-1:0]              o_max_value,
    input wire                                       o_last,
    input wire                                       o_cfg_ready
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // reset empties the queue, so samples are taken at once
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("sample channel not ready right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_column)
            && $stable(o_min_value) && $stable(o_max_value) && $stable(o_last))
        else $error("stalled result beat changed");

    // configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind minmax_envelope_decimator_top mmed_checker u_mmed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_column    (o_column),
    .o_min_value (o_min_value),
    .o_max_value (o_max_value),
    .o_last      (o_last),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

@@ dv/minmax_envelope_decimator_top_tb.sv @@
// Self-checking testbench for the min/max envelope decimator: random and directed sample streams.
module minmax_envelope_decimator_top_tb;

    localparam int MAX_COLS = 8;
    localparam int TB_IDX_W = $clog2(MAX_COLS);
    localparam logic [mmed_pkg::SAMPLE_W-1:0] MOST_NEG = {1'b1, {(mmed_pkg::SAMPLE_W-1){1'b0}}};
    localparam logic [mmed_pkg::SAMPLE_W-1:0] MOST_POS = {1'b0, {(mmed_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic [mmed_pkg::SAMPLE_W-1:0] ALL_ONES = {mmed_pkg::SAMPLE_W{1'b1}};
    // Index that decodes to no register; a write there must change nothing.
    localparam logic [mmed_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd9;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // One envelope beat as the result channel carries it.
    typedef struct packed {
        logic [mmed_pkg::OUTCOL_W-1:0] column;
        logic [mmed_pkg::SAMPLE_W-1:0] min_value;
        logic [mmed_pkg::SAMPLE_W-1:0] max_value;
        logic                          last;
    } t_envelope;

    // Clock, reset and every DUT input start from a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [mmed_pkg::SAMPLE_W-1:0] in_sample = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [mmed_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mmed_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic in_ready, out_valid, out_last, cfg_ready;
    logic [mmed_pkg::OUTCOL_W-1:0] out_column;
    logic signed [mmed_pkg::SAMPLE_W-1:0] out_min, out_max;

    always #5 clk = ~clk;

    minmax_envelope_decimator_top #(
        .MAX_COLUMNS(MAX_COLS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_sample   (in_sample),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_column   (out_column),
        .o_min_value(out_min),
        .o_max_value(out_max),
        .o_last     (out_last),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Samples waiting to be offered, and envelopes the block still owes us.
    logic [mmed_pkg::SAMPLE_W-1:0] sample_q[$];
    t_envelope envelope_q[$];
    int mismatch_cnt = 0;
    t_idle_mode idle_mode = IDLE_NONE;

    // Receiver hold-off: bump hold_req to start a long stretch with ready low.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Shadow of the block: configuration, counters and per-column trackers.
    logic [mmed_pkg::AXES_W-1:0] cfg_axes = 6'd1;
    logic [mmed_pkg::ROW_W-1:0] cfg_spb = 16'd1;
    logic [mmed_pkg::COL_W-1:0] col_cnt = '0;
    logic [mmed_pkg::ROW_W-1:0] row_cnt = '0;
    logic signed [mmed_pkg::SAMPLE_W-1:0] col_min[0:MAX_COLS-1];
    logic signed [mmed_pkg::SAMPLE_W-1:0] col_max[0:MAX_COLS-1];
    // Tracker entries loaded since reset; the rest hold no defined value.
    bit col_loaded[0:MAX_COLS-1] = '{default: 1'b0};

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Axis count the block honors: zero means one, anything past 32 means 32.
    function automatic int axes_in_use(input logic [mmed_pkg::AXES_W-1:0] a);
        if (a == 0) return 1;
        if (a > 32) return 32;
        return int'(a);
    endfunction

    // Fold one accepted sample into the trackers; queue the envelope it emits.
    task automatic track_sample(input logic signed [mmed_pkg::SAMPLE_W-1:0] s);
        int axes, kept, rows;
        bit last_row;
        t_envelope env;
        logic [TB_IDX_W-1:0] ci;
        axes = axes_in_use(cfg_axes);
        kept = (axes < MAX_COLS) ? axes : MAX_COLS;
        rows = (cfg_spb == 0) ? 1 : int'(cfg_spb);
        last_row = int'(row_cnt) >= rows - 1;
        ci = col_cnt[TB_IDX_W-1:0];
        if (int'(col_cnt) < kept) begin
            if (row_cnt == 0) begin
                col_min[ci] = s;
                col_max[ci] = s;
                col_loaded[ci] = 1'b1;
            end else if (s < col_min[ci]) begin
                col_min[ci] = s;
            end else if (s > col_max[ci]) begin
                col_max[ci] = s;
            end
            if (last_row) begin
                env.column = col_cnt[mmed_pkg::OUTCOL_W-1:0];
                env.min_value = col_min[ci];
                env.max_value = col_max[ci];
                env.last = (int'(col_cnt) == kept - 1);
                envelope_q.push_back(env);
            end
        end
        // Wrap the column at the end of a row; wrap the row at the end of a bucket.
        if (int'(col_cnt) >= axes - 1) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 85;
            IDLE_BOTH: return $urandom_range(0, 99) < 27;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 85;
            IDLE_BOTH: return $urandom_range(0, 99) < 27;
            default:   return 1'b0;
        endcase
    endfunction

    // Mix of extremes, a narrow band that forces ties, and full-range values.
    function automatic logic [mmed_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Sample driver: hold valid and payload until the beat is taken, then
    // advance to the next queued sample unless the sender rests this cycle.
    always @(posedge clk) begin : drive_samples
        logic nxt_valid;
        logic [mmed_pkg::SAMPLE_W-1:0] nxt_sample;
        nxt_valid = in_valid;
        nxt_sample = in_sample;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                track_sample(in_sample);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && sample_q.size() != 0 && !sender_rests()) begin
                nxt_valid = 1'b1;
                nxt_sample = sample_q.pop_front();
            end
        end
        in_valid <= nxt_valid;
        in_sample <= nxt_sample;
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    // Result monitor: compare every taken beat with the oldest owed envelope.
    always @(posedge clk) begin : watch_results
        t_envelope want;
        if (rst_n && out_valid && out_ready) begin
            if (envelope_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat: column %0d min %0d max %0d last %0b",
                                        out_column, out_min, out_max, out_last));
            end else begin
                want = envelope_q.pop_front();
                if (out_column !== want.column)
                    flag_mismatch($sformatf("column: got %0d, want %0d",
                                            out_column, want.column));
                if (out_min !== want.min_value)
                    flag_mismatch($sformatf("min_value (column %0d): got %0d, want %0d",
                                            want.column, out_min, $signed(want.min_value)));
                if (out_max !== want.max_value)
                    flag_mismatch($sformatf("max_value (column %0d): got %0d, want %0d",
                                            want.column, out_max, $signed(want.max_value)));
                if (out_last !== want.last)
                    flag_mismatch($sformatf("last (column %0d): got %0b, want %0b",
                                            want.column, out_last, want.last));
            end
        end
        out_ready <= rst_n && hold_left == 0 && !receiver_stalls();
    end

    // Wait until every queued sample has been taken by the block.
    task automatic settle_input();
        do @(negedge clk); while (sample_q.size() != 0 || in_valid);
    endtask

    // Wait for full idle: input drained, nothing owed, pipeline flushed.
    task automatic settle_all();
        do @(negedge clk); while (sample_q.size() != 0 || in_valid || envelope_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Feed filler samples one at a time until the stream sits at a bucket start.
    task automatic align();
        settle_input();
        while (row_cnt != 0 || col_cnt != 0) begin
            sample_q.push_back(pick_sample());
            settle_input();
        end
    endtask

    // One register write; the shadow copy changes on the same beat.
    task automatic write_reg(input logic [mmed_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mmed_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mmed_pkg::REG_NUM_AXES)
            cfg_axes = data[mmed_pkg::AXES_W-1:0];
        else if (idx == mmed_pkg::REG_SPB)
            cfg_spb = data[mmed_pkg::ROW_W-1:0];
        @(negedge clk);
    endtask

    // Reconfigure while idle. Counters keep running across the write, so a
    // mid-bucket change is fine unless it would bring a never-loaded tracker
    // into a later row; align to a bucket start first in that case.
    task automatic set_config(input logic [mmed_pkg::CFG_DATA_W-1:0] axes,
                              input logic [mmed_pkg::CFG_DATA_W-1:0] spb);
        int kept;
        bit covered;
        settle_all();
        kept = axes_in_use(axes[mmed_pkg::AXES_W-1:0]);
        if (kept > MAX_COLS) kept = MAX_COLS;
        covered = 1'b1;
        for (int c = 0; c < kept; c++)
            if (!col_loaded[TB_IDX_W'(c)]) covered = 1'b0;
        if (!covered && (row_cnt != 0 || col_cnt != 0)) begin
            align();
            settle_all();
        end
        write_reg(mmed_pkg::REG_NUM_AXES, axes);
        write_reg(mmed_pkg::REG_SPB, spb);
    endtask

    task automatic run_phase(input logic [mmed_pkg::CFG_DATA_W-1:0] axes,
                             input logic [mmed_pkg::CFG_DATA_W-1:0] spb,
                             input t_idle_mode mode, input int count);
        set_config(axes, spb);
        idle_mode = mode;
        repeat (count) sample_q.push_back(pick_sample());
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset config, one axis and one row: every sample is its own envelope.
        sample_q.push_back(MOST_NEG);
        sample_q.push_back(MOST_POS);
        sample_q.push_back('0);
        sample_q.push_back(ALL_ONES);

        // More axes than kept columns, zero bucket length acting as one row.
        set_config(16'd10, 16'd0);
        for (int c = 0; c < 10; c++)
            sample_q.push_back(c[0] ? MOST_POS : MOST_NEG);

        // Two-row buckets: the second row raises the maximum in both trackers.
        set_config(16'd2, 16'd2);
        sample_q.push_back(32'd5);
        sample_q.push_back(MOST_NEG);
        sample_q.push_back(MOST_POS);
        sample_q.push_back(-32'sd3);

        // Shorten the bucket mid-row: the row in progress becomes the last one.
        set_config(16'd3, 16'd3);
        repeat (4) sample_q.push_back(pick_sample());
        set_config(16'd3, 16'd2);
        repeat (2) sample_q.push_back(pick_sample());

        // Random phases across settings and idle patterns.
        run_phase(16'd1, 16'd1, IDLE_NONE, 120);
        run_phase(16'd3, 16'd4, IDLE_SEND, 120);
        run_phase(16'd8, 16'd2, IDLE_RECV, 120);
        run_phase(16'd9, 16'd3, IDLE_BOTH, 120);

        // Backpressure: stall the receiver long enough to fill the block and
        // choke its input, then pause the sender until every envelope is in.
        set_config(16'd1, 16'd1);
        idle_mode = IDLE_NONE;
        hold_req++;
        repeat (80) sample_q.push_back(pick_sample());
        settle_all();
        idle_mode = IDLE_BOTH;
        repeat (60) sample_q.push_back(pick_sample());

        run_phase(16'd32, 16'd1, IDLE_BOTH, 150);
        run_phase(16'd63, 16'd5, IDLE_RECV, 150);
        run_phase(16'd0, 16'd0, IDLE_SEND, 100);

        // Longest bucket length, single axis, from a clean bucket boundary;
        // the next phase shortens it so the open bucket closes on its next row.
        align();
        set_config(16'd1, 16'hFFFF);
        idle_mode = IDLE_NONE;
        repeat (60) sample_q.push_back(pick_sample());

        run_phase(16'd4, 16'd6, IDLE_NONE, 120);

        // Junk above the axis field, plus a write to an undecoded index.
        set_config(16'hFFC6, 16'd3);
        write_reg(REG_SPARE, 16'hA5A5);
        idle_mode = IDLE_BOTH;
        repeat (120) sample_q.push_back(pick_sample());

        run_phase(16'd33, 16'd2, IDLE_NONE, 120);
        repeat (4)
            run_phase(16'($urandom_range(0, 63)), 16'($urandom_range(0, 7)),
                      t_idle_mode'($urandom_range(0, 3)), int'($urandom_range(40, 80)));

        // Drain: give owed envelopes a bounded time, then flush the pipeline.
        settle_input();
        for (int w = 0; w < 5000 && envelope_q.size() != 0; w++) @(negedge clk);
        repeat (10) @(negedge clk);
        if (envelope_q.size() != 0)
            flag_mismatch($sformatf("%0d envelopes never arrived", envelope_q.size()));
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mmed_pkg.sv
rtl/mmed_front.sv
rtl/mmed_queue.sv
rtl/mmed_back.sv
rtl/minmax_envelope_decimator_top.sv
rtl/mmed_checker.sv
dv/minmax_envelope_decimator_top_tb.sv
